// ===== rtl/shipsb_pkg.sv =====
// shared types and fixed constants of the stream-bypass replacement block
package shipsb_pkg;

    // input item packing in s_tdata, lowest bit first
    localparam int unsigned SET_IN_W  = 11;
    localparam int unsigned WAY_IN_W  = 5;
    localparam int unsigned ADDR_W    = 48;
    localparam int unsigned PCSIG_W   = 6;
    localparam int unsigned S_DATA_W  = 72;
    localparam int unsigned M_DATA_W  = 8;

    localparam int unsigned SET_LO    = 0;
    localparam int unsigned WAY_LO    = SET_LO + SET_IN_W;
    localparam int unsigned ADDR_LO   = WAY_LO + WAY_IN_W;
    localparam int unsigned PCSIG_LO  = ADDR_LO + ADDR_W;
    localparam int unsigned HIT_POS   = PCSIG_LO + PCSIG_W;

    // fixed-point reciprocal shift used for the set modulo
    localparam int unsigned RECIP_SHIFT = 22;

    // stride distances and counter limits
    localparam logic [ADDR_W-1:0] STRIDE_ONE = 48'd64;
    localparam logic [ADDR_W-1:0] STRIDE_TWO = 48'd128;
    localparam logic [1:0]        CTR_MAX    = 2'd3;
    localparam logic [1:0]        CTR_MIN    = 2'd0;
    localparam logic [1:0]        RRPV_MAX   = 2'd3;
    localparam logic [1:0]        RRPV_NEAR  = 2'd2;
    localparam logic [1:0]        RRPV_HIT   = 2'd0;
    localparam logic [1:0]        REUSE_INIT = 2'd1;

    // function codes
    localparam logic FUNC_VICTIM = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    // configuration register indexes
    localparam logic CFG_STREAM_THR = 1'b0;
    localparam logic CFG_REUSE_THR  = 1'b1;

    // register reset values
    localparam logic [1:0] STREAM_THR_RST = 2'd3;
    localparam logic [1:0] REUSE_THR_RST  = 2'd2;

    // controller states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_SET,
        ST_EVAL,
        ST_HIT_INC,
        ST_MISS_INS,
        ST_MISS_PEN,
        ST_OUT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic clr;
        logic accept;
        logic div;
        logic set_rd;
        logic eval;
        logic hit_inc;
        logic miss_ins;
        logic miss_pen;
        logic load_out;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic clr_done;
        logic end_early;
        logic hit;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/shipsb_ctrl.sv =====
// sequencing state machine of the stream-bypass replacement block
module shipsb_ctrl
    import shipsb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div    = 1'b1;
                state_next = ST_SET;
            end
            ST_SET:
            begin
                cmd.set_rd = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                if (sts.end_early)
                begin
                    state_next = ST_OUT;
                end
                else if (sts.hit)
                begin
                    state_next = ST_HIT_INC;
                end
                else
                begin
                    state_next = ST_MISS_INS;
                end
            end
            ST_HIT_INC:
            begin
                cmd.hit_inc = 1'b1;
                state_next  = ST_OUT;
            end
            ST_MISS_INS:
            begin
                cmd.miss_ins = 1'b1;
                state_next   = ST_MISS_PEN;
            end
            ST_MISS_PEN:
            begin
                cmd.miss_pen = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// ===== rtl/shipsb_dp.sv =====
// datapath: metadata memories, stride detector, victim search and output register
module shipsb_dp
    import shipsb_pkg::*;
#(
    parameter int NUM_SETS = 2048,
    parameter int NUM_WAYS = 16,
    parameter int SIG_BITS = 6
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output sts_t                sts,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tuser,
    input  logic                cfg_wr,
    input  logic                cfg_index,
    input  logic [1:0]          cfg_data
);

    localparam int SET_W     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W     = $clog2(NUM_WAYS);
    localparam int SIG_COUNT = 1 << SIG_BITS;
    localparam int CLR_N     = (NUM_SETS > SIG_COUNT) ? NUM_SETS : SIG_COUNT;
    localparam int CLR_W     = $clog2(CLR_N);
    localparam int RROW_W    = 2 * NUM_WAYS;
    localparam int SROW_W    = SIG_BITS * NUM_WAYS;
    localparam int SETM_W    = ADDR_W + 3;
    localparam int RECIP     = (1 << RECIP_SHIFT) / NUM_SETS;
    localparam int PROD_W    = SET_IN_W + RECIP_SHIFT;
    localparam int REM_W     = 28;
    localparam logic [WAY_IN_W:0]   WAYS_EXT = (WAY_IN_W + 1)'(NUM_WAYS);
    localparam logic [WAY_IN_W-1:0] BYP_WAY  = WAY_IN_W'(NUM_WAYS);

    // memories
    logic [SETM_W-1:0] set_mem  [NUM_SETS];
    logic [RROW_W-1:0] rrpv_mem [NUM_SETS];
    logic [SROW_W-1:0] sig_mem  [NUM_SETS];
    logic [1:0]        reuse_mem[SIG_COUNT];

    // item and config registers
    logic                func_reg;
    logic [SET_IN_W-1:0] raw_set_reg;
    logic [WAY_IN_W-1:0] way_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [SIG_BITS-1:0] sig_reg;
    logic                hit_reg;
    logic [SET_IN_W-1:0] quot_reg;
    logic [SET_W-1:0]    set_reg;
    logic [1:0]          stream_thr_reg;
    logic [1:0]          reuse_thr_reg;
    logic [CLR_W-1:0]    clr_cnt_reg;
    logic [SETM_W-1:0]   set_rd_reg;
    logic [RROW_W-1:0]   rrpv_rd_reg;
    logic [SROW_W-1:0]   sig_rd_reg;
    logic [1:0]          reuse_rd_reg;
    logic [SIG_BITS-1:0] reuse_addr_reg;
    logic [SIG_BITS-1:0] evict_reg;
    logic [WAY_IN_W-1:0] res_way_reg;
    logic                res_byp_reg;
    logic                m_tvalid_reg;
    logic [WAY_IN_W-1:0] m_way_reg;
    logic                m_byp_reg;

    // combinational datapath signals
    logic [PROD_W-1:0]   prod;
    logic [REM_W-1:0]    rem_raw;
    logic [REM_W-1:0]    rem_fix;
    logic [SET_W-1:0]    set_cur;
    logic [ADDR_W-1:0]   hist_addr;
    logic                hist_valid;
    logic [1:0]          scnt;
    logic [ADDR_W-1:0]   diff_fwd;
    logic [ADDR_W-1:0]   diff_bwd;
    logic [ADDR_W-1:0]   addr_dist;
    logic                stride;
    logic [1:0]          scnt_new;
    logic                byp_old;
    logic                byp_new;
    logic                way_oob;
    logic [WAY_W-1:0]    way_idx;
    logic [SIG_BITS-1:0] old_sig;
    logic                any3;
    logic                any2;
    logic                any1;
    logic [1:0]          top;
    logic [WAY_IN_W-1:0] victim;
    logic                found;
    logic [RROW_W-1:0]   aged_row;
    logic [1:0]          ins_val;
    logic [RROW_W-1:0]   put_row;
    logic [SROW_W-1:0]   sig_row;
    logic                upd_go;
    logic                clr_set;
    logic                clr_sig;
    logic                set_we;
    logic [SET_W-1:0]    row_waddr;
    logic [SETM_W-1:0]   set_wdata;
    logic                rrpv_we;
    logic [RROW_W-1:0]   rrpv_wdata;
    logic                sig_we;
    logic [SROW_W-1:0]   sig_wdata;
    logic                reuse_we;
    logic [SIG_BITS-1:0] reuse_waddr;
    logic [1:0]          reuse_wdata;
    logic                reuse_re;
    logic [SIG_BITS-1:0] reuse_raddr;
    logic                row_re;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_thr_reg <= STREAM_THR_RST;
            reuse_thr_reg  <= REUSE_THR_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                CFG_STREAM_THR: stream_thr_reg <= cfg_data;
                CFG_REUSE_THR:  reuse_thr_reg  <= cfg_data;
                default:        stream_thr_reg <= stream_thr_reg;
            endcase
        end
    end

    // clearing sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr && !sts.clr_done)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // item capture and set modulo by reciprocal multiply
    assign prod    = PROD_W'(raw_set_reg) * PROD_W'(RECIP);
    assign rem_raw = REM_W'(raw_set_reg) - REM_W'(quot_reg) * REM_W'(NUM_SETS);
    assign rem_fix = (rem_raw >= REM_W'(NUM_SETS)) ? rem_raw - REM_W'(NUM_SETS) : rem_raw;
    assign set_cur = rem_fix[SET_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg    <= s_tuser;
            raw_set_reg <= s_tdata[SET_LO +: SET_IN_W];
            way_reg     <= s_tdata[WAY_LO +: WAY_IN_W];
            addr_reg    <= s_tdata[ADDR_LO +: ADDR_W];
            sig_reg     <= SIG_BITS'(s_tdata[PCSIG_LO +: PCSIG_W]);
            hit_reg     <= s_tdata[HIT_POS];
        end
        if (cmd.div)
        begin
            quot_reg <= prod[PROD_W-1 -: SET_IN_W];
        end
        if (cmd.set_rd)
        begin
            set_reg <= set_cur;
        end
    end

    // stride detector on the absolute distance to the set's last address
    assign hist_addr  = set_rd_reg[ADDR_W-1:0];
    assign hist_valid = set_rd_reg[ADDR_W];
    assign scnt       = set_rd_reg[ADDR_W+2 -: 2];
    assign diff_fwd   = addr_reg - hist_addr;
    assign diff_bwd   = hist_addr - addr_reg;
    assign addr_dist  = (addr_reg > hist_addr) ? diff_fwd : diff_bwd;
    assign stride     = hist_valid && (addr_dist == STRIDE_ONE || addr_dist == STRIDE_TWO);

    always_comb
    begin
        if (stride)
        begin
            scnt_new = (scnt == CTR_MAX) ? CTR_MAX : scnt + 2'd1;
        end
        else
        begin
            scnt_new = (scnt == CTR_MIN) ? CTR_MIN : scnt - 2'd1;
        end
    end

    assign byp_old = scnt >= stream_thr_reg;
    assign byp_new = scnt_new >= stream_thr_reg;
    assign way_oob = {1'b0, way_reg} >= WAYS_EXT;
    assign way_idx = way_reg[WAY_W-1:0];
    assign old_sig = sig_rd_reg[32'(way_idx) * SIG_BITS +: SIG_BITS];
    assign upd_go  = (func_reg == FUNC_UPDATE) && !byp_new && !way_oob;

    // victim search: largest rrpv, first way holding it, then age the row
    always_comb
    begin
        any3 = 1'b0;
        any2 = 1'b0;
        any1 = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            any3 = any3 | (rrpv_rd_reg[2*w +: 2] == 2'd3);
            any2 = any2 | (rrpv_rd_reg[2*w +: 2] == 2'd2);
            any1 = any1 | (rrpv_rd_reg[2*w +: 2] == 2'd1);
        end
        top = any3 ? 2'd3 : (any2 ? 2'd2 : (any1 ? 2'd1 : 2'd0));
        victim = '0;
        found  = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (!found && rrpv_rd_reg[2*w +: 2] == top)
            begin
                victim = WAY_IN_W'(w);
                found  = 1'b1;
            end
        end
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            aged_row[2*w +: 2] = rrpv_rd_reg[2*w +: 2] + (RRPV_MAX - top);
        end
    end

    // single-way row updates for hit promotion and miss insertion
    always_comb
    begin
        ins_val = cmd.miss_ins
                ? ((reuse_rd_reg >= reuse_thr_reg) ? RRPV_NEAR : RRPV_MAX)
                : RRPV_HIT;
        put_row = rrpv_rd_reg;
        sig_row = sig_rd_reg;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (WAY_W'(w) == way_idx)
            begin
                put_row[2*w +: 2]               = ins_val;
                sig_row[w*SIG_BITS +: SIG_BITS] = sig_reg;
            end
        end
    end

    // memory write and read controls
    assign clr_set   = cmd.clr && (32'(clr_cnt_reg) < NUM_SETS);
    assign clr_sig   = cmd.clr && (32'(clr_cnt_reg) < SIG_COUNT);
    assign row_waddr = cmd.clr ? clr_cnt_reg[SET_W-1:0] : set_reg;
    assign row_re    = cmd.set_rd;

    assign set_we    = clr_set || (cmd.eval && func_reg == FUNC_UPDATE);
    assign set_wdata = cmd.clr ? '0 : {scnt_new, 1'b1, addr_reg};

    always_comb
    begin
        rrpv_we    = 1'b0;
        rrpv_wdata = put_row;
        if (cmd.clr)
        begin
            rrpv_we    = clr_set;
            rrpv_wdata = '1;
        end
        else if (cmd.eval && func_reg == FUNC_VICTIM)
        begin
            rrpv_we    = !byp_old;
            rrpv_wdata = aged_row;
        end
        else if (cmd.eval)
        begin
            rrpv_we = upd_go && hit_reg;
        end
        else if (cmd.miss_ins)
        begin
            rrpv_we = 1'b1;
        end
    end

    assign sig_we    = clr_set || cmd.miss_ins;
    assign sig_wdata = cmd.clr ? '0 : sig_row;

    assign reuse_we    = clr_sig || cmd.hit_inc || cmd.miss_pen;
    assign reuse_waddr = cmd.clr ? clr_cnt_reg[SIG_BITS-1:0] : reuse_addr_reg;
    always_comb
    begin
        if (cmd.clr)
        begin
            reuse_wdata = REUSE_INIT;
        end
        else if (cmd.hit_inc)
        begin
            reuse_wdata = (reuse_rd_reg == CTR_MAX) ? CTR_MAX : reuse_rd_reg + 2'd1;
        end
        else
        begin
            reuse_wdata = (reuse_rd_reg == CTR_MIN) ? CTR_MIN : reuse_rd_reg - 2'd1;
        end
    end

    assign reuse_re    = (cmd.eval && upd_go) || cmd.miss_ins;
    assign reuse_raddr = cmd.miss_ins ? evict_reg : (hit_reg ? old_sig : sig_reg);

    // set memory
    always_ff @(posedge clk)
    begin
        if (set_we)
        begin
            set_mem[row_waddr] <= set_wdata;
        end
        if (row_re)
        begin
            set_rd_reg <= set_mem[set_cur];
        end
    end

    // rrpv row memory
    always_ff @(posedge clk)
    begin
        if (rrpv_we)
        begin
            rrpv_mem[row_waddr] <= rrpv_wdata;
        end
        if (row_re)
        begin
            rrpv_rd_reg <= rrpv_mem[set_cur];
        end
    end

    // signature row memory
    always_ff @(posedge clk)
    begin
        if (sig_we)
        begin
            sig_mem[row_waddr] <= sig_wdata;
        end
        if (row_re)
        begin
            sig_rd_reg <= sig_mem[set_cur];
        end
    end

    // reuse counter memory
    always_ff @(posedge clk)
    begin
        if (reuse_we)
        begin
            reuse_mem[reuse_waddr] <= reuse_wdata;
        end
        if (reuse_re)
        begin
            reuse_rd_reg   <= reuse_mem[reuse_raddr];
            reuse_addr_reg <= reuse_raddr;
        end
    end

    // evicted signature and result of the item
    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            evict_reg <= old_sig;
            if (func_reg == FUNC_VICTIM)
            begin
                res_way_reg <= byp_old ? BYP_WAY : victim;
                res_byp_reg <= byp_old;
            end
            else
            begin
                res_way_reg <= '0;
                res_byp_reg <= byp_new;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            m_way_reg <= res_way_reg;
            m_byp_reg <= res_byp_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_DATA_W'(m_way_reg);
    assign m_tuser  = m_byp_reg;

    // status
    assign sts.clr_done  = clr_cnt_reg == CLR_W'(CLR_N - 1);
    assign sts.end_early = (func_reg == FUNC_VICTIM) || !upd_go;
    assign sts.hit       = hit_reg;
    assign sts.out_free  = !m_tvalid_reg || m_tready;

endmodule

// ===== rtl/ship_rrip_stream_bypass_replacement.sv =====
// top level of the cache replacement block with stream bypass
//
// Replacement policy for a last-level cache: 2-bit RRPV per way, signature
// based insertion depth and a per-set stride detector that bypasses
// streaming sets. Items arrive on the s_ stream: tuser selects victim
// search (0) or access update (1). One result item leaves on the m_ stream
// for every input item. The user must write thresholds on the cfg_ channel
// only while the block is idle; the block leaves this to the user and
// cfg_ready is always high. Each item passes from acceptance to the output
// register through the modulo of the set index (ST_DIV), one registered
// read of the set's rows (ST_SET) and the evaluation (ST_EVAL); an update
// that is not bypassed and names a way in range then does a read-modify-write
// of the reuse counters, on hit through ST_HIT_INC, on miss through
// ST_MISS_INS and ST_MISS_PEN. The next item is taken once the result is in the output register.
// After reset the block clears all memories, one set row and one reuse
// counter a cycle, s_tready low, over max(NUM_SETS, 2**SIG_BITS) entries.
// A stalled receiver holds the result in the output register; the next
// item may still be processed up to the point of delivering its result.
module ship_rrip_stream_bypass_replacement
    import shipsb_pkg::*;
#(
    parameter int NUM_SETS = 2048,
    parameter int NUM_WAYS = 16,
    parameter int SIG_BITS = 6
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // set_index[10:0], way[15:11], address[63:16], pc_signature[69:64], hit[70]
    input  logic [S_DATA_W-1:0] s_tdata,
    // func[0]
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // victim_way[4:0]
    output logic [M_DATA_W-1:0] m_tdata,
    // bypass[0]
    output logic                m_tuser,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [1:0]          cfg_data
);

    cmd_t cmd;
    sts_t sts;

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    // sequencer
    shipsb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // memories and arithmetic
    shipsb_dp #(
        .NUM_SETS (NUM_SETS),
        .NUM_WAYS (NUM_WAYS),
        .SIG_BITS (SIG_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

// ===== rtl/shipsb_chk.sv =====
// port checker for the replacement block and its bind
module shipsb_chk
    import shipsb_pkg::*;
#(
    parameter int NUM_WAYS = 16
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tuser
);

    localparam logic [4:0] BYP_WAY = 5'(NUM_WAYS);

    // a result waiting on a stalled receiver stays
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    // a stalled result keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is in work");

    // a bypass result carries either the bypass way or the update marker
    a_bypass_way: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[4:0] == BYP_WAY || m_tdata[4:0] == 5'd0)
        else $error("bypass result with a real victim way");

    // unused result bits stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[M_DATA_W-1:5] == '0)
        else $error("padding bits of result item set");

endmodule

bind ship_rrip_stream_bypass_replacement shipsb_chk #(
    .NUM_WAYS (NUM_WAYS)
) u_shipsb_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== verif/ship_rrip_stream_bypass_replacement_tb.sv =====
// testbench for the stream-bypass cache replacement block: directed and random items
`timescale 1ns / 100ps

module ship_rrip_stream_bypass_replacement_tb;
    import shipsb_pkg::*;

    localparam int SETS = 2048;
    localparam int WAYS = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    // one predicted result
    typedef struct {
        logic [4:0] victim_way;
        logic       bypass;
    } repl_result_t;

    // scoreboard: predictor state and the queue of predicted results
    class repl_scoreboard;
        logic [1:0]  rrpv [SETS*WAYS];
        logic [5:0]  blk_sig [SETS*WAYS];
        logic [1:0]  reuse_ctr [64];
        logic [47:0] prev_addr [SETS];
        bit          seen [SETS];
        logic [1:0]  stride_ctr [SETS];
        logic [1:0]  stream_thr;
        logic [1:0]  reuse_thr;
        repl_result_t pending [$];
        int          fails;

        function new();
            foreach (rrpv[i]) rrpv[i] = RRPV_MAX;
            foreach (blk_sig[i]) blk_sig[i] = '0;
            foreach (reuse_ctr[i]) reuse_ctr[i] = REUSE_INIT;
            foreach (prev_addr[i]) prev_addr[i] = '0;
            foreach (seen[i]) seen[i] = 0;
            foreach (stride_ctr[i]) stride_ctr[i] = '0;
            stream_thr = STREAM_THR_RST;
            reuse_thr = REUSE_THR_RST;
            fails = 0;
        endfunction

        function void write_reg(logic idx, logic [1:0] val);
            if (idx == CFG_STREAM_THR)
                stream_thr = val;
            else
                reuse_thr = val;
        endfunction

        // note an accepted input item and predict its result
        function void note_item(logic fn, logic [S_DATA_W-1:0] d);
            int s, w, base, idx;
            logic [47:0] a, delta;
            logic [5:0] sig, ev;
            logic [1:0] top;
            logic [4:0] best;
            repl_result_t r;
            s = d[SET_LO +: SET_IN_W] % SETS;
            w = d[WAY_LO +: WAY_IN_W];
            a = d[ADDR_LO +: ADDR_W];
            sig = d[PCSIG_LO +: PCSIG_W];
            base = s * WAYS;
            if (fn == FUNC_VICTIM) begin
                if (stride_ctr[s] >= stream_thr) begin
                    r.victim_way = 5'(WAYS);
                    r.bypass = 1'b1;
                end
                else begin
                    top = '0;
                    best = '0;
                    for (int i = 0; i < WAYS; i++)
                        if (rrpv[base+i] > top) begin
                            top = rrpv[base+i];
                            best = 5'(i);
                        end
                    for (int i = 0; i < WAYS; i++)
                        rrpv[base+i] = rrpv[base+i] + (RRPV_MAX - top);
                    r.victim_way = best;
                    r.bypass = 1'b0;
                end
                pending.push_back(r);
                return;
            end
            // train the stride detector
            delta = (a > prev_addr[s]) ? a - prev_addr[s] : prev_addr[s] - a;
            if (seen[s] && (delta == STRIDE_ONE || delta == STRIDE_TWO)) begin
                if (stride_ctr[s] < CTR_MAX) stride_ctr[s]++;
            end
            else if (stride_ctr[s] > CTR_MIN) stride_ctr[s]--;
            prev_addr[s] = a;
            seen[s] = 1;
            r.victim_way = 0;
            r.bypass = stride_ctr[s] >= stream_thr;
            pending.push_back(r);
            if (r.bypass || w >= WAYS) return;
            idx = base + w;
            if (d[HIT_POS]) begin
                rrpv[idx] = RRPV_HIT;
                if (reuse_ctr[blk_sig[idx]] < CTR_MAX) reuse_ctr[blk_sig[idx]]++;
            end
            else begin
                ev = blk_sig[idx];
                blk_sig[idx] = sig;
                rrpv[idx] = (reuse_ctr[sig] >= reuse_thr) ? RRPV_NEAR : RRPV_MAX;
                if (reuse_ctr[ev] > CTR_MIN) reuse_ctr[ev]--;
            end
        endfunction

        // compare an accepted result item with the oldest prediction
        function void check_result(logic [M_DATA_W-1:0] d, logic u);
            repl_result_t e;
            if (pending.size() == 0) begin
                $error("result item with nothing expected: victim_way %0d bypass %0d",
                       d[4:0], u);
                fails++;
                return;
            end
            e = pending.pop_front();
            if (d !== {3'b000, e.victim_way}) begin
                $error("victim_way expected %0d actual %0d", e.victim_way, d);
                fails++;
            end
            if (u !== e.bypass) begin
                $error("bypass expected %0d actual %0d", e.bypass, u);
                fails++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;
    logic                cfg_valid;
    logic                cfg_ready;
    logic                cfg_index;
    logic [1:0]          cfg_data;

    repl_scoreboard sb;
    int  idle_cycles = 0;
    bit  hold_off;
    bit  stim_done;

    ship_rrip_stream_bypass_replacement dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver: random stalls, and one long hold-off on request
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_off = 0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            if (stim_done) gap = 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            sb.check_result(m_tdata, m_tuser);
        end
    end

    // send one item, with the given gap in front
    task automatic send_item(input logic fn, input logic [10:0] set_i,
                             input logic [4:0] way_i, input logic [47:0] addr_i,
                             input logic [5:0] sig_i, input logic hit_i, input int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= fn;
        s_tdata <= {1'b0, hit_i, sig_i, addr_i, way_i, set_i};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_item(fn, {1'b0, hit_i, sig_i, addr_i, way_i, set_i});
    endtask

    task automatic rand_item(input int gap, input logic [10:0] set_i, input bit stride);
        logic [47:0] a;
        a = 48'({$urandom(), $urandom()});
        if (stride)
            a = sb.prev_addr[set_i] + (($urandom_range(0, 1) != 0) ? 48'd64 : 48'd128);
        send_item(1'($urandom_range(0, 1)), set_i,
                  ($urandom_range(0, 7) == 0) ? 5'(WAYS + $urandom_range(0, 15))
                                              : 5'($urandom_range(0, WAYS - 1)),
                  a, 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)), gap);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic rand_phase(input int n);
        logic [10:0] hot;
        int gap;
        hot = 11'($urandom_range(0, 7));
        for (int i = 0; i < n; i++) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            if ($urandom_range(0, 9) < 7) begin
                // mostly a few hot sets, often with stride addresses
                hot = ($urandom_range(0, 3) == 0) ? 11'($urandom_range(0, 7)) : hot;
                rand_item(gap, hot, $urandom_range(0, 2) != 0);
            end
            else
                rand_item(gap, 11'($urandom_range(0, 2047)), 0);
        end
    endtask

    // stimulus
    initial
    begin
        sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_STREAM_THR;
        cfg_data = '0;
        hold_off = 0;
        stim_done = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, hit and miss, bypassed way, stride build-up
        send_item(FUNC_VICTIM, 11'd0, 5'd0, 48'd0, 6'd0, 1'b0, 0);
        send_item(FUNC_UPDATE, 11'd0, 5'd0, 48'd0, 6'd63, 1'b0, 0);
        send_item(FUNC_UPDATE, 11'd0, 5'd0, 48'd64, 6'd63, 1'b1, 0);
        send_item(FUNC_UPDATE, 11'd0, 5'd15, 48'd192, 6'd5, 1'b0, 0);
        send_item(FUNC_UPDATE, 11'd0, 5'd16, 48'd256, 6'd5, 1'b0, 0);
        send_item(FUNC_VICTIM, 11'd0, 5'd31, 48'hFFFF_FFFF_FFFF, 6'd63, 1'b1, 0);
        send_item(FUNC_UPDATE, 11'd0, 5'd31, 48'd320, 6'd0, 1'b1, 0);
        send_item(FUNC_UPDATE, 11'd2047, 5'd3, 48'hFFFF_FFFF_FFFF, 6'd63, 1'b0, 0);
        send_item(FUNC_UPDATE, 11'd2047, 5'd3, 48'hFFFF_FFFF_FFBF, 6'd63, 1'b0, 0);
        send_item(FUNC_VICTIM, 11'd2047, 5'd0, 48'd0, 6'd0, 1'b0, 0);
        send_item(FUNC_UPDATE, 11'd5, 5'd2, 48'h5555_5555_5555, 6'h2A, 1'b0, 0);
        send_item(FUNC_UPDATE, 11'd5, 5'd2, 48'hAAAA_AAAA_AAAA, 6'h15, 1'b1, 0);
        send_item(FUNC_VICTIM, 11'd5, 5'd0, 48'd0, 6'd0, 1'b0, 0);
        send_item(FUNC_VICTIM, 11'd5, 5'd0, 48'd0, 6'd0, 1'b0, 0);
        drain();

        // settings across the extremes, including threshold zero
        write_reg(CFG_STREAM_THR, 2'd0);
        write_reg(CFG_REUSE_THR, 2'd0);
        send_item(FUNC_VICTIM, 11'd9, 5'd0, 48'd0, 6'd0, 1'b0, 0);
        send_item(FUNC_UPDATE, 11'd9, 5'd1, 48'd1000, 6'd1, 1'b0, 0);
        rand_phase(30);
        drain();
        write_reg(CFG_STREAM_THR, 2'd1);
        write_reg(CFG_REUSE_THR, 2'd3);
        rand_phase(130);
        drain();
        write_reg(CFG_STREAM_THR, 2'd2);
        write_reg(CFG_REUSE_THR, 2'd1);
        // long receiver hold-off while items keep coming
        hold_off = 1;
        rand_phase(130);
        drain();
        write_reg(CFG_STREAM_THR, 2'd3);
        write_reg(CFG_REUSE_THR, 2'd2);
        rand_phase(130);
        drain();
        write_reg(CFG_STREAM_THR, 2'd1);
        write_reg(CFG_REUSE_THR, 2'd0);
        rand_phase(100);

        // wait for every result, then settle
        stim_done = 1;
        drain();
        if (sb.fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== ship_rrip_stream_bypass_replacement.f =====
rtl/shipsb_pkg.sv
rtl/shipsb_ctrl.sv
rtl/shipsb_dp.sv
rtl/ship_rrip_stream_bypass_replacement.sv
rtl/shipsb_chk.sv
verif/ship_rrip_stream_bypass_replacement_tb.sv
